// ===== sv/phong_shading_unit_assert.svh =====
// Assertion macros shared by the shading unit RTL.
`ifndef PHONG_SHADING_UNIT_ASSERT_SVH
`define PHONG_SHADING_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define PHS_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define PHS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/phs_pkg.sv =====
// Shared types, constants and elaboration-time helpers of the shading unit.
`default_nettype none

package phs_pkg;

	localparam int UNIT_W   = 16;
	localparam int FRAC_W   = 14;
	localparam int UNIT_ONE = 16384;
	localparam int VEC_W    = 25;

	typedef enum logic [7:0] {
		REG_EYE_X         = 8'd0,
		REG_EYE_Y         = 8'd1,
		REG_EYE_Z         = 8'd2,
		REG_LAMP_X        = 8'd3,
		REG_LAMP_Y        = 8'd4,
		REG_LAMP_Z        = 8'd5,
		REG_LAMP_RGB      = 8'd6,
		REG_LAMP_STRENGTH = 8'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [23:0] hit_x;
		logic signed [23:0] hit_y;
		logic signed [23:0] hit_z;
		logic [15:0]        diffuse_coef;
		logic [15:0]        specular_coef;
		logic [15:0]        shininess;
	} hit_t;

	typedef struct packed {
		logic [23:0] shade_red;
		logic [23:0] shade_green;
		logic [23:0] shade_blue;
	} shade_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [47:0] value;
	} cfg_t;

	// Integer square root, only evaluated while elaborating constants.
	function automatic logic [63:0] isqrt_const(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		x = v;
		for (int j = 0; j < 32; j++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Factors 2^(-2^-i), i = 1..16, in Q1.30, from repeated roots of one half.
	function automatic logic [15:0][30:0] exp_roots();
		logic [15:0][30:0] tab;
		logic [63:0]       rt;
		rt = 64'd1 << 29;
		for (int i = 0; i < 16; i++) begin
			rt = isqrt_const(rt << 30);
			tab[i] = rt[30:0];
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

// ===== sv/phs_chan_if.sv =====
// Valid/ready channel carrying one payload beat.
`default_nettype none

interface phs_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/phs_unitize.sv =====
// Pipelined vector normalizer: squares, bit-serial square root, restoring division.
`default_nettype none

module phs_unitize
	import phs_pkg::*;
#(
	parameter int IN_W = 25,
	parameter int SB_W = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [IN_W-1:0]   vec [3],
	input  logic [SB_W-1:0]          in_sb,
	output logic                     out_valid,
	output logic                     out_nz,
	output logic signed [UNIT_W-1:0] unit [3],
	output logic [SB_W-1:0]          out_sb
);
	localparam int SQ_W = 2 * IN_W;
	localparam int S_W  = 2 * IN_W + 2;
	localparam int R_W  = S_W / 2;
	localparam int QB   = FRAC_W + 1;
	localparam int D_W  = IN_W + QB;
	localparam int LAT  = R_W + QB + 4;

	typedef struct packed {
		logic [2:0][IN_W-1:0] mag;
		logic [2:0]           neg;
		logic                 nz;
		logic [SB_W-1:0]      sb;
	} car_t;

	typedef struct packed {
		logic [2:0]      neg;
		logic            nz;
		logic [SB_W-1:0] sb;
	} dvc_t;

	logic [LAT-1:0]         vld_s;
	car_t                   car_s1;
	car_t                   car_s2;
	logic [2:0][SQ_W-1:0]   sq_s2;
	logic [S_W-1:0]         sq_sum;
	logic [S_W-1:0]         rtv_s [R_W+1];
	logic [S_W-1:0]         rtr_s [R_W+1];
	car_t                   rtc_s [R_W+1];
	logic [S_W-1:0]         rtv_n [R_W];
	logic [S_W-1:0]         rtr_n [R_W];
	logic [R_W-1:0]         len_s [QB+1];
	logic [2:0][D_W-1:0]    rem_s [QB+1];
	logic [2:0][QB-1:0]     quo_s [QB+1];
	dvc_t                   dvc_s [QB+1];
	logic [2:0][D_W-1:0]    rem_n [QB];
	logic [2:0][QB-1:0]     quo_n [QB];

	assign sq_sum = S_W'(sq_s2[0]) + S_W'(sq_s2[1]) + S_W'(sq_s2[2]);

	// One result bit of the square root per stage.
	always_comb begin
		logic [S_W-1:0] bitv;
		for (int j = 0; j < R_W; j++) begin
			bitv = S_W'(1) << (2 * (R_W - 1 - j));
			if (rtv_s[j] >= rtr_s[j] + bitv) begin
				rtv_n[j] = rtv_s[j] - (rtr_s[j] + bitv);
				rtr_n[j] = (rtr_s[j] >> 1) + bitv;
			end else begin
				rtv_n[j] = rtv_s[j];
				rtr_n[j] = rtr_s[j] >> 1;
			end
		end
	end

	// One quotient bit per stage for each of the three components.
	always_comb begin
		logic [D_W-1:0] dsh;
		for (int k = 0; k < QB; k++) begin
			dsh = D_W'(len_s[k]) << (QB - 1 - k);
			for (int c = 0; c < 3; c++) begin
				if (rem_s[k][c] >= dsh) begin
					rem_n[k][c] = rem_s[k][c] - dsh;
					quo_n[k][c] = quo_s[k][c] | (QB'(1) << (QB - 1 - k));
				end else begin
					rem_n[k][c] = rem_s[k][c];
					quo_n[k][c] = quo_s[k][c];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				car_s1.neg[c] <= vec[c][IN_W-1];
				car_s1.mag[c] <= vec[c][IN_W-1] ? IN_W'(-vec[c]) : IN_W'(vec[c]);
				sq_s2[c]      <= SQ_W'(car_s1.mag[c]) * SQ_W'(car_s1.mag[c]);
			end
			car_s1.nz <= 1'b0;
			car_s1.sb <= in_sb;
			car_s2    <= car_s1;

			rtv_s[0] <= sq_sum;
			rtr_s[0] <= '0;
			rtc_s[0] <= '{mag: car_s2.mag, neg: car_s2.neg, nz: (sq_sum != '0), sb: car_s2.sb};
			for (int j = 0; j < R_W; j++) begin
				rtv_s[j+1] <= rtv_n[j];
				rtr_s[j+1] <= rtr_n[j];
				rtc_s[j+1] <= rtc_s[j];
			end

			len_s[0] <= rtr_s[R_W][R_W-1:0];
			for (int c = 0; c < 3; c++) begin
				rem_s[0][c] <= D_W'(rtc_s[R_W].mag[c]) << FRAC_W;
			end
			quo_s[0] <= '0;
			dvc_s[0] <= '{neg: rtc_s[R_W].neg, nz: rtc_s[R_W].nz, sb: rtc_s[R_W].sb};
			for (int k = 0; k < QB; k++) begin
				len_s[k+1] <= len_s[k];
				rem_s[k+1] <= rem_n[k];
				quo_s[k+1] <= quo_n[k];
				dvc_s[k+1] <= dvc_s[k];
			end
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign out_nz    = dvc_s[QB].nz;
	assign out_sb    = dvc_s[QB].sb;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			unit[c] = dvc_s[QB].neg[c] ? -$signed(UNIT_W'(quo_s[QB][c]))
			                           : $signed(UNIT_W'(quo_s[QB][c]));
		end
	end

endmodule

`default_nettype wire

// ===== sv/phs_power.sv =====
// Pipelined power b^s in Q1.14 through a base-2 logarithm and exponential.
`default_nettype none

module phs_power
	import phs_pkg::*;
#(
	parameter int SB_W = 48
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [14:0]     base,
	input  logic [15:0]     expo,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_valid,
	output logic [14:0]     result,
	output logic [SB_W-1:0] out_sb
);
	localparam int LOG_N = 16;
	localparam int EXP_N = 16;
	localparam int LAT   = LOG_N + EXP_N + 4;
	localparam logic [15:0][30:0] ROOTS = exp_roots();

	typedef struct packed {
		logic [3:0]      k;
		logic [15:0]     s;
		logic            one;
		logic            zero;
		logic [SB_W-1:0] sb;
	} car_t;

	logic [LAT-1:0] vld_s;
	logic [3:0]     lead;
	logic [30:0]    lm_s [LOG_N+1];
	logic [15:0]    lf_s [LOG_N+1];
	car_t           lc_s [LOG_N+1];
	logic [30:0]    lm_n [LOG_N];
	logic [15:0]    lf_n [LOG_N];
	logic [19:0]    t_s;
	car_t           tc_s;
	logic [27:0]    eu_s [EXP_N+1];
	logic [30:0]    ea_s [EXP_N+1];
	car_t           ec_s [EXP_N+1];
	logic [30:0]    ea_n [EXP_N];
	logic [11:0]    ipart;
	logic [14:0]    res_s;
	logic [SB_W-1:0] sb_s;

	// Position of the leading one of the base.
	always_comb begin
		lead = '0;
		for (int j = 0; j < 15; j++) begin
			if (base[j]) begin
				lead = 4'(j);
			end
		end
	end

	// Logarithm: square the normalized mantissa, one fraction bit per stage.
	always_comb begin
		logic [61:0] sq;
		for (int i = 0; i < LOG_N; i++) begin
			sq = 62'(lm_s[i]) * 62'(lm_s[i]);
			if (sq[61]) begin
				lm_n[i] = sq[61:31];
				lf_n[i] = lf_s[i] | (16'(1) << (15 - i));
			end else begin
				lm_n[i] = sq[60:30];
				lf_n[i] = lf_s[i];
			end
		end
	end

	// Exponential: multiply in the root factor of each set fraction bit.
	always_comb begin
		logic [61:0] pr;
		for (int i = 0; i < EXP_N; i++) begin
			pr = 62'(ea_s[i]) * 62'(ROOTS[i]);
			ea_n[i] = eu_s[i][15-i] ? pr[60:30] : ea_s[i];
		end
	end

	assign ipart = eu_s[EXP_N][27:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lm_s[0] <= 31'(base) << (5'd30 - 5'(lead));
			lf_s[0] <= '0;
			lc_s[0] <= '{k: lead, s: expo, one: (expo == '0), zero: (base == '0), sb: in_sb};
			for (int i = 0; i < LOG_N; i++) begin
				lm_s[i+1] <= lm_n[i];
				lf_s[i+1] <= lf_n[i];
				lc_s[i+1] <= lc_s[i];
			end

			t_s  <= (20'd14 << 16) - {lc_s[LOG_N].k, lf_s[LOG_N]};
			tc_s <= lc_s[LOG_N];

			eu_s[0] <= 28'((36'(t_s) * 36'(tc_s.s)) >> 8);
			ea_s[0] <= 31'(1) << 30;
			ec_s[0] <= tc_s;
			for (int i = 0; i < EXP_N; i++) begin
				eu_s[i+1] <= eu_s[i];
				ea_s[i+1] <= ea_n[i];
				ec_s[i+1] <= ec_s[i];
			end

			if (ec_s[EXP_N].one) begin
				res_s <= 15'(UNIT_ONE);
			end else if (ec_s[EXP_N].zero || ipart >= 12'd15) begin
				res_s <= '0;
			end else begin
				res_s <= 15'(ea_s[EXP_N] >> (5'(ipart[3:0]) + 5'd16));
			end
			sb_s <= ec_s[EXP_N].sb;
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign result    = res_s;
	assign out_sb    = sb_s;

endmodule

`default_nettype wire

// ===== sv/phong_shading_unit.sv =====
// Top level of the Phong shading unit.
`default_nettype none

// Phong shading unit. Each beat on hit carries one surface hit (normal, hit
// point, diffuse and specular coefficients, shininess); each beat on shade
// carries the RGB radiance of that hit against the point light and viewer
// set through cfg. The unit is fully pipelined: it accepts one hit per clock
// cycle while the output is not stalled and returns results in order. Its
// depth is mostly in the two normalizer passes (a 26-step bit-serial square
// root and a 15-step restoring divider, one step per stage, 45 stages each)
// and in the 36-stage power unit (16 logarithm steps, 16 exponential
// steps). The whole pipeline advances whenever the output register is empty
// or its beat is being taken, so hit.ready drops only while a finished beat
// waits on shade and bubbles stay in place. Configuration writes on cfg are
// always accepted and should only be made while no hit is in flight; a
// write to an index beyond the register list is ignored. A zero-length
// normal, light or view vector, or a reflection vector that quantizes to
// zero, yields black.

module phong_shading_unit
	import phs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	phs_chan_if.sink   hit,
	phs_chan_if.source shade,
	phs_chan_if.sink   cfg
);

`include "phong_shading_unit_assert.svh"

	typedef struct packed {
		logic [2:0][15:0] vu;
		logic [14:0]      cos_t;
		logic [15:0]      kd;
		logic [15:0]      ks;
		logic [15:0]      sh;
		logic             ok;
	} rside_t;

	typedef struct packed {
		logic [15:0] kd;
		logic [15:0] ks;
		logic [14:0] cos_t;
		logic        ok;
	} pside_t;

	// Clamp a Q2.28 dot product to a Q1.14 cosine in [0, 1].
	function automatic logic [14:0] clamp_cos(logic signed [31:0] d);
		logic signed [17:0] c;
		c = 18'(d >>> FRAC_W);
		if (c < 0) begin
			return '0;
		end else if (c > 18'sd16384) begin
			return 15'(UNIT_ONE);
		end else begin
			return c[14:0];
		end
	endfunction

	logic en;

	// Configuration registers.
	logic signed [23:0] eye_q [3];
	logic signed [23:0] lamp_q [3];
	logic [47:0]        rgb_q;
	logic [15:0]        strength_q;

	logic signed [23:0] hit_pos [3];

	// Front stage: direction vectors.
	logic                     vld_s1;
	logic signed [VEC_W-1:0]  n_s1 [3];
	logic signed [VEC_W-1:0]  l_s1 [3];
	logic signed [VEC_W-1:0]  v_s1 [3];
	logic [15:0]              kd_s1, ks_s1, sh_s1;

	// First normalizer outputs.
	logic signed [UNIT_W-1:0] nu_u [3];
	logic signed [UNIT_W-1:0] lu_u [3];
	logic signed [UNIT_W-1:0] vu_u [3];
	logic                     nz_n, nz_l, nz_v;
	logic                     val_n, val_l, val_v;
	logic [15:0]              kd_u, ks_u, sh_u;

	logic                     vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [31:0]       p_s2 [3];
	logic signed [UNIT_W-1:0] nu_s2 [3], lu_s2 [3], vu_s2 [3];
	logic                     ok_s2;
	logic [15:0]              kd_s2, ks_s2, sh_s2;
	logic signed [31:0]       d_s3;
	logic signed [UNIT_W-1:0] nu_s3 [3], lu_s3 [3], vu_s3 [3];
	logic                     ok_s3;
	logic [15:0]              kd_s3, ks_s3, sh_s3;
	logic signed [47:0]       dn_s4 [3];
	logic [14:0]              cos_t_s4;
	logic signed [UNIT_W-1:0] lu_s4 [3], vu_s4 [3];
	logic                     ok_s4;
	logic [15:0]              kd_s4, ks_s4, sh_s4;
	logic signed [VEC_W-1:0]  r_s5 [3];
	rside_t                   rside_s5;

	// Reflection normalizer outputs.
	logic signed [UNIT_W-1:0] ru_u [3];
	logic                     nz_r, val_r;
	rside_t                   rside_u;

	logic                     vld_s6, vld_s7;
	logic signed [31:0]       pr_s6 [3];
	logic                     ok_s6, ok_s7;
	logic [14:0]              cos_t_s6, cos_t_s7;
	logic [15:0]              kd_s6, ks_s6, sh_s6;
	logic [15:0]              kd_s7, ks_s7, sh_s7;
	logic [14:0]              cos_a_s7;

	// Power unit outputs.
	logic                     val_p;
	logic [14:0]              spec_p;
	pside_t                   pside_p;

	// Color stages.
	logic                     vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic [30:0]              dt_s8, st_s8;
	logic                     ok_s8;
	logic [31:0]              sum_s9;
	logic [47:0]              sc_s10 [3];
	logic [63:0]              ss_s11 [3];
	shade_t                   shade_s12;

	// The pipeline moves as one; it stops only when a finished beat waits.
	assign en = !vld_s12 || shade.ready;

	assign hit.ready   = en;
	assign cfg.ready   = 1'b1;
	assign shade.valid = vld_s12;
	assign shade.data  = shade_s12;

	assign hit_pos[0] = hit.data.hit_x;
	assign hit_pos[1] = hit.data.hit_y;
	assign hit_pos[2] = hit.data.hit_z;

	// Register file. Narrow registers keep the low bits of the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				eye_q[c]  <= '0;
				lamp_q[c] <= '0;
			end
			rgb_q      <= '0;
			strength_q <= 16'd4096;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_EYE_X:         eye_q[0]   <= cfg.data.value[23:0];
				REG_EYE_Y:         eye_q[1]   <= cfg.data.value[23:0];
				REG_EYE_Z:         eye_q[2]   <= cfg.data.value[23:0];
				REG_LAMP_X:        lamp_q[0]  <= cfg.data.value[23:0];
				REG_LAMP_Y:        lamp_q[1]  <= cfg.data.value[23:0];
				REG_LAMP_Z:        lamp_q[2]  <= cfg.data.value[23:0];
				REG_LAMP_RGB:      rgb_q      <= cfg.data.value;
				REG_LAMP_STRENGTH: strength_q <= cfg.data.value[15:0];
				default: begin
				end
			endcase
		end
	end

	// Valid bits of the stages that live in this module.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s1  <= hit.valid;
			vld_s2  <= val_n && val_l && val_v;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= val_r;
			vld_s7  <= vld_s6;
			vld_s8  <= val_p;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	// Stage 1: normal, light direction L = lamp - hit, view direction V = eye - hit.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1[0] <= VEC_W'(hit.data.normal_x);
			n_s1[1] <= VEC_W'(hit.data.normal_y);
			n_s1[2] <= VEC_W'(hit.data.normal_z);
			for (int c = 0; c < 3; c++) begin
				l_s1[c] <= VEC_W'(lamp_q[c]) - VEC_W'(hit_pos[c]);
				v_s1[c] <= VEC_W'(eye_q[c]) - VEC_W'(hit_pos[c]);
			end
			kd_s1 <= hit.data.diffuse_coef;
			ks_s1 <= hit.data.specular_coef;
			sh_s1 <= hit.data.shininess;
		end
	end

	// The three normalizers run side by side, each carrying one material field.
	phs_unitize #(.IN_W(VEC_W), .SB_W(16)) u_norm_n (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s1),
		.vec(n_s1), .in_sb(sh_s1),
		.out_valid(val_n), .out_nz(nz_n), .unit(nu_u), .out_sb(sh_u)
	);

	phs_unitize #(.IN_W(VEC_W), .SB_W(16)) u_norm_l (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s1),
		.vec(l_s1), .in_sb(kd_s1),
		.out_valid(val_l), .out_nz(nz_l), .unit(lu_u), .out_sb(kd_u)
	);

	phs_unitize #(.IN_W(VEC_W), .SB_W(16)) u_norm_v (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s1),
		.vec(v_s1), .in_sb(ks_s1),
		.out_valid(val_v), .out_nz(nz_v), .unit(vu_u), .out_sb(ks_u)
	);

	// Stages 2 to 5: d = L.N (also the diffuse cosine), then R = 2 d N - L.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				p_s2[c] <= 32'(lu_u[c]) * 32'(nu_u[c]);
			end
			nu_s2 <= nu_u;
			lu_s2 <= lu_u;
			vu_s2 <= vu_u;
			ok_s2 <= nz_n && nz_l && nz_v;
			kd_s2 <= kd_u;
			ks_s2 <= ks_u;
			sh_s2 <= sh_u;

			d_s3  <= p_s2[0] + p_s2[1] + p_s2[2];
			nu_s3 <= nu_s2;
			lu_s3 <= lu_s2;
			vu_s3 <= vu_s2;
			ok_s3 <= ok_s2;
			kd_s3 <= kd_s2;
			ks_s3 <= ks_s2;
			sh_s3 <= sh_s2;

			for (int c = 0; c < 3; c++) begin
				dn_s4[c] <= 48'(d_s3) * 48'(nu_s3[c]);
			end
			cos_t_s4 <= clamp_cos(d_s3);
			lu_s4    <= lu_s3;
			vu_s4    <= vu_s3;
			ok_s4    <= ok_s3;
			kd_s4    <= kd_s3;
			ks_s4    <= ks_s3;
			sh_s4    <= sh_s3;

			// Floor division by 2^27 is an arithmetic shift.
			for (int c = 0; c < 3; c++) begin
				r_s5[c]        <= VEC_W'((dn_s4[c] >>> 27) - 48'(lu_s4[c]));
				rside_s5.vu[c] <= vu_s4[c];
			end
			rside_s5.cos_t <= cos_t_s4;
			rside_s5.kd    <= kd_s4;
			rside_s5.ks    <= ks_s4;
			rside_s5.sh    <= sh_s4;
			rside_s5.ok    <= ok_s4;
		end
	end

	phs_unitize #(.IN_W(VEC_W), .SB_W($bits(rside_t))) u_norm_r (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s5),
		.vec(r_s5), .in_sb(rside_s5),
		.out_valid(val_r), .out_nz(nz_r), .unit(ru_u), .out_sb(rside_u)
	);

	// Stages 6 and 7: specular cosine R.V, clamped.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pr_s6[c] <= 32'(ru_u[c]) * 32'($signed(rside_u.vu[c]));
			end
			ok_s6    <= rside_u.ok && nz_r;
			cos_t_s6 <= rside_u.cos_t;
			kd_s6    <= rside_u.kd;
			ks_s6    <= rside_u.ks;
			sh_s6    <= rside_u.sh;

			cos_a_s7 <= clamp_cos(pr_s6[0] + pr_s6[1] + pr_s6[2]);
			ok_s7    <= ok_s6;
			cos_t_s7 <= cos_t_s6;
			kd_s7    <= kd_s6;
			ks_s7    <= ks_s6;
			sh_s7    <= sh_s6;
		end
	end

	phs_power #(.SB_W($bits(pside_t))) u_power (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s7),
		.base(cos_a_s7), .expo(sh_s7),
		.in_sb(pside_t'{kd: kd_s7, ks: ks_s7, cos_t: cos_t_s7, ok: ok_s7}),
		.out_valid(val_p), .result(spec_p), .out_sb(pside_p)
	);

	// Stages 8 to 12: kd cos + ks spec, times color, times strength.
	// The sum stays below 2^31, so the shifted product always fits in 24 bits
	// and the output never needs to clip.
	always_ff @(posedge clk) begin
		if (en) begin
			dt_s8 <= 31'(pside_p.kd) * 31'(pside_p.cos_t);
			st_s8 <= 31'(pside_p.ks) * 31'(spec_p);
			ok_s8 <= pside_p.ok;

			sum_s9 <= ok_s8 ? 32'(dt_s8) + 32'(st_s8) : '0;

			for (int c = 0; c < 3; c++) begin
				sc_s10[c] <= 48'(sum_s9) * 48'(rgb_q[16*c +: 16]);
				ss_s11[c] <= 64'(sc_s10[c]) * 64'(strength_q);
			end

			shade_s12.shade_red   <= 24'(ss_s11[0][63:41]);
			shade_s12.shade_green <= 24'(ss_s11[1][63:41]);
			shade_s12.shade_blue  <= 24'(ss_s11[2][63:41]);
		end
	end

	// A stall must hold the valid bits of stages 1, 5, 8 and 12 steady.
	`PHS_ASSERT_NEXT(a_stall_freezes, !en, $stable({vld_s1, vld_s5, vld_s8, vld_s12}), "pipeline moved during a stall")
	// A degenerate vector must force a black sum.
	`PHS_ASSERT_NEXT(a_fail_black, en && vld_s8 && !ok_s8, sum_s9 == '0, "degenerate hit not black")
	// The diffuse cosine never exceeds one.
	`PHS_ASSERT_SAME(a_cos_range, vld_s4, cos_t_s4 <= 15'(UNIT_ONE), "diffuse cosine above one")

endmodule

`default_nettype wire
